// ----- sv/lla_pkg.sv -----
// Shared types, constants and helpers of the life-like automaton engine.
package lla_pkg;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int CFG_SIZE_W = 7;
   localparam int MASK_W     = 9;
   localparam int COUNT_W    = 4;
   localparam int SIZE_LIMIT = 2 ** CFG_SIZE_W;

   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 64;

   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_ROWS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COLS    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BORN    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SURVIVE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WRAP    = 3'd4;

   localparam logic [CFG_SIZE_W-1:0] ROWS_RESET    = 7'd64;
   localparam logic [CFG_SIZE_W-1:0] COLS_RESET    = 7'd64;
   localparam logic [MASK_W-1:0]     BORN_RESET    = 9'd8;
   localparam logic [MASK_W-1:0]     SURVIVE_RESET = 9'd12;
   localparam logic                  WRAP_RESET    = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_STEP  = 2'd3
   } lla_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CELL_DONE,
      ST_GEN_FIRST,
      ST_GEN_LOAD,
      ST_GEN_SWEEP,
      ST_GEN_DONE
   } lla_state_type;

   typedef struct packed {
      logic capture;
      logic cell_read;
      logic cell_finish;
      logic gen_read_last;
      logic gen_read_first;
      logic gen_load;
      logic gen_sweep;
      logic rsp_load;
   } lla_cmd_type;

   typedef struct packed {
      logic is_step;
      logic last_row;
   } lla_status_type;

   // Rows or columns that can ever take part: the size registers top out below SIZE_LIMIT.
   function automatic int used_dim(input int max_dim);
      return (max_dim < SIZE_LIMIT) ? max_dim : SIZE_LIMIT;
   endfunction

endpackage

// ----- sv/life_like_automaton_engine.sv -----
// Top level of the life-like automaton engine: register file, controller and datapath.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_operation, req_row, req_col
//   rsp       out        rsp_valid / rsp_stall  rsp_cell_alive, rsp_in_range
//   csr       in/out     psel, penable, pready  paddr, pwrite, pwdata, prdata
//
// Set, clear and read pass from transfer through decode, one grid memory read, then write
// back and load the result register; no new item is taken until that is done.
// In a generation step the sweep reads one row per cycle through the single read port
// of the grid memory, after two reads that fetch the last and first rows for the
// wrap-around window.
// Reset clears the grid at once through per-row valid flags; no clearing pass runs.
// A stalled result holds in the output register while the next item is taken.
module life_like_automaton_engine import lla_pkg::*; #(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [ROW_W-1:0]   req_row,
   input  logic [COL_W-1:0]   req_col,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_cell_alive,
   output logic               rsp_in_range,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int USED_ROWS = used_dim(MAX_ROWS);
   localparam int USED_COLS = used_dim(MAX_COLS);
   localparam int NRW = $clog2(USED_ROWS + 1);
   localparam int NCW = $clog2(USED_COLS + 1);

   logic [CFG_SIZE_W-1:0] rows_ff, rows_in;
   logic [CFG_SIZE_W-1:0] cols_ff, cols_in;
   logic [MASK_W-1:0]     born_ff, born_in;
   logic [MASK_W-1:0]     survive_ff, survive_in;
   logic                  wrap_ff, wrap_in;
   logic                  csr_write;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [NRW-1:0]        active_rows;
   logic [NCW-1:0]        active_cols;

   lla_cmd_type    cmd;
   lla_status_type status;

   // ---- register file ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[PADDR_W-1:2];

   always_comb begin
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      born_in    = born_ff;
      survive_in = survive_ff;
      wrap_in    = wrap_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ROWS:    rows_in    = pwdata[CFG_SIZE_W-1:0];
            REG_COLS:    cols_in    = pwdata[CFG_SIZE_W-1:0];
            REG_BORN:    born_in    = pwdata[MASK_W-1:0];
            REG_SURVIVE: survive_in = pwdata[MASK_W-1:0];
            REG_WRAP:    wrap_in    = pwdata[0];
            default:     ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_RESET;
         cols_ff    <= COLS_RESET;
         born_ff    <= BORN_RESET;
         survive_ff <= SURVIVE_RESET;
         wrap_ff    <= WRAP_RESET;
      end else begin
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         born_ff    <= born_in;
         survive_ff <= survive_in;
         wrap_ff    <= wrap_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROWS:    prdata = PDATA_W'(rows_ff);
         REG_COLS:    prdata = PDATA_W'(cols_ff);
         REG_BORN:    prdata = PDATA_W'(born_ff);
         REG_SURVIVE: prdata = PDATA_W'(survive_ff);
         REG_WRAP:    prdata = PDATA_W'(wrap_ff);
         default:     prdata = '0;
      endcase
   end

   // Effective grid size: zero acts as one, oversize clamps to the grid.
   always_comb begin
      if (rows_ff == '0) begin
         active_rows = NRW'(1);
      end else if (int'(rows_ff) > USED_ROWS) begin
         active_rows = NRW'(USED_ROWS);
      end else begin
         active_rows = NRW'(rows_ff);
      end
      if (cols_ff == '0) begin
         active_cols = NCW'(1);
      end else if (int'(cols_ff) > USED_COLS) begin
         active_cols = NCW'(USED_COLS);
      end else begin
         active_cols = NCW'(cols_ff);
      end
   end

   // ---- controller ----
   lla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // ---- datapath ----
   lla_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_row        (req_row),
      .req_col        (req_col),
      .active_rows    (active_rows),
      .active_cols    (active_cols),
      .born_mask      (born_ff),
      .survive_mask   (survive_ff),
      .wrap_edges     (wrap_ff),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_in_range   (rsp_in_range)
   );

endmodule

// ----- sv/lla_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module lla_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lla_ctrl.sv -----
// Controller state machine: sequences cell operations and the generation sweep.
module lla_ctrl import lla_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  lla_status_type status,
   output lla_cmd_type    cmd
);

   lla_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_step) begin
               cmd.gen_read_last = 1'b1;
               state_in          = ST_GEN_FIRST;
            end else begin
               cmd.cell_read = 1'b1;
               state_in      = ST_CELL_DONE;
            end
         end
         ST_CELL_DONE: begin
            // hold the read data until the result register frees up
            if (slot_free) begin
               cmd.cell_finish = 1'b1;
               cmd.rsp_load    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_GEN_FIRST: begin
            cmd.gen_read_first = 1'b1;
            state_in           = ST_GEN_LOAD;
         end
         ST_GEN_LOAD: begin
            cmd.gen_load = 1'b1;
            state_in     = ST_GEN_SWEEP;
         end
         ST_GEN_SWEEP: begin
            cmd.gen_sweep = 1'b1;
            if (status.last_row) begin
               state_in = ST_GEN_DONE;
            end
         end
         ST_GEN_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != ST_IDLE);

endmodule

// ----- sv/lla_datapath.sv -----
// Datapath: grid memory, row window, neighbor rule and result register.
module lla_datapath import lla_pkg::*; #(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   localparam int USED_ROWS = used_dim(MAX_ROWS),
   localparam int USED_COLS = used_dim(MAX_COLS),
   localparam int NRW = $clog2(USED_ROWS + 1),
   localparam int NCW = $clog2(USED_COLS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  lla_cmd_type       cmd,
   output lla_status_type    status,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [COL_W-1:0]  req_col,
   input  logic [NRW-1:0]    active_rows,
   input  logic [NCW-1:0]    active_cols,
   input  logic [MASK_W-1:0] born_mask,
   input  logic [MASK_W-1:0] survive_mask,
   input  logic              wrap_edges,
   output logic              rsp_cell_alive,
   output logic              rsp_in_range
);

   localparam int RIDX_W = $clog2(USED_ROWS);
   localparam int CIDX_W = $clog2(USED_COLS);
   localparam int CMP_W  = CFG_SIZE_W + 1;
   localparam int SEL_W  = COL_W + 1;

   function automatic logic apply_rule(input logic [7:0] nb, input logic self_alive,
                                       input logic [MASK_W-1:0] born,
                                       input logic [MASK_W-1:0] survive);
      logic [COUNT_W-1:0] count;
      count = '0;
      for (int k = 0; k < 8; k++) begin
         count = count + COUNT_W'(nb[k]);
      end
      return self_alive ? survive[count] : born[count];
   endfunction

   // captured item
   lla_op_type         op_ff, op_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               in_range;

   // memory ports
   logic               rd_en, wr_en;
   logic [RIDX_W-1:0]  rd_addr, wr_addr;
   logic [USED_COLS-1:0] wr_data, ram_q, rd_row;
   logic [USED_ROWS-1:0] row_valid_ff, row_valid_in;
   logic               rd_valid_ff, rd_valid_in;

   // sweep state
   logic [NRW-1:0]     rd_idx_ff, rd_idx_in;
   logic [RIDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [RIDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [USED_COLS-1:0] up_ff, up_in, mid_ff, mid_in;
   logic [USED_COLS-1:0] first_ff, first_in, last_ff, last_in;
   logic [USED_COLS-1:0] nxt_ff, nxt_in;
   logic [RIDX_W-1:0]  last_row_idx;
   logic               last_row;

   // rule evaluation
   logic [USED_COLS-1:0] col_mask, up_m, mid_m, dn_m, dn_sel, gen_row;
   logic [USED_COLS+1:0] up_p, mid_p, dn_p;
   logic [CIDX_W-1:0]  edge_idx;
   logic [7:0]         nb;

   // cell operation
   logic [USED_COLS-1:0] col_sel, cell_row;
   logic               cell_wr, new_bit;

   // result register
   logic               alive_ff, alive_in, range_ff, range_in;

   assign in_range = (CMP_W'(row_ff) < CMP_W'(active_rows))
                  && (CMP_W'(col_ff) < CMP_W'(active_cols));
   assign last_row_idx = RIDX_W'(active_rows - NRW'(1));
   assign last_row     = (cmp_idx_ff == last_row_idx);
   assign status.is_step  = (op_ff == OP_STEP);
   assign status.last_row = last_row;

   // ---- read side ----
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff[RIDX_W-1:0];
      if (cmd.cell_read) begin
         rd_en   = in_range;
         rd_addr = RIDX_W'(row_ff);
      end else if (cmd.gen_read_last) begin
         rd_en   = 1'b1;
         rd_addr = last_row_idx;
      end else if (cmd.gen_read_first) begin
         rd_en   = 1'b1;
         rd_addr = '0;
      end else if (cmd.gen_load || cmd.gen_sweep) begin
         rd_en = (rd_idx_ff < active_rows);
      end
   end

   assign rd_valid_in = rd_en ? row_valid_ff[rd_addr] : rd_valid_ff;
   // rows never written since reset read as dead
   assign rd_row = ram_q & {USED_COLS{rd_valid_ff}};

   // ---- generation rule over one row ----
   always_comb begin
      for (int j = 0; j < USED_COLS; j++) begin
         col_mask[j] = (j < int'(active_cols));
      end
   end

   assign dn_sel   = last_row ? (wrap_edges ? first_ff : '0) : rd_row;
   assign up_m     = up_ff & col_mask;
   assign mid_m    = mid_ff & col_mask;
   assign dn_m     = dn_sel & col_mask;
   assign up_p     = {1'b0, up_m, 1'b0};
   assign mid_p    = {1'b0, mid_m, 1'b0};
   assign dn_p     = {1'b0, dn_m, 1'b0};
   assign edge_idx = CIDX_W'(active_cols - NCW'(1));

   always_comb begin
      nb = '0;
      for (int j = 0; j < USED_COLS; j++) begin
         nb = {up_p[j], mid_p[j], dn_p[j], up_p[j+1], dn_p[j+1],
               up_p[j+2], mid_p[j+2], dn_p[j+2]};
         if (j == 0) begin
            nb[7:5] = wrap_edges ? {up_m[edge_idx], mid_m[edge_idx], dn_m[edge_idx]} : 3'b000;
         end
         if (CIDX_W'(j) == edge_idx) begin
            nb[2:0] = wrap_edges ? {up_m[0], mid_m[0], dn_m[0]} : 3'b000;
         end
         // columns beyond the active width keep their value
         gen_row[j] = col_mask[j] ? apply_rule(nb, mid_m[j], born_mask, survive_mask)
                                  : mid_ff[j];
      end
   end

   // ---- cell operation ----
   always_comb begin
      for (int j = 0; j < USED_COLS; j++) begin
         col_sel[j] = (SEL_W'(col_ff) == SEL_W'(j));
      end
   end

   assign cell_row = (op_ff == OP_SET) ? (rd_row | col_sel) : (rd_row & ~col_sel);
   assign cell_wr  = cmd.cell_finish && in_range && ((op_ff == OP_SET) || (op_ff == OP_CLEAR));
   assign new_bit  = (op_ff == OP_SET)   ? 1'b1 :
                     (op_ff == OP_CLEAR) ? 1'b0 : |(rd_row & col_sel);

   // ---- write side ----
   assign wr_en   = wr_pend_ff || cell_wr;
   assign wr_addr = wr_pend_ff ? wr_idx_ff : RIDX_W'(row_ff);
   assign wr_data = wr_pend_ff ? nxt_ff : cell_row;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   lla_ram #(
      .WIDTH (USED_COLS),
      .DEPTH (USED_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // ---- next values ----
   always_comb begin
      op_in      = op_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      wr_idx_in  = wr_idx_ff;
      wr_pend_in = cmd.gen_sweep;
      up_in      = up_ff;
      mid_in     = mid_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      nxt_in     = nxt_ff;
      alive_in   = alive_ff;
      range_in   = range_ff;

      if (cmd.capture) begin
         op_in  = lla_op_type'(req_operation);
         row_in = req_row;
         col_in = req_col;
      end
      if (cmd.gen_read_first) begin
         last_in   = rd_row;
         rd_idx_in = NRW'(1);
      end
      if ((cmd.gen_load || cmd.gen_sweep) && (rd_idx_ff < active_rows)) begin
         rd_idx_in = rd_idx_ff + NRW'(1);
      end
      if (cmd.gen_load) begin
         mid_in     = rd_row;
         first_in   = rd_row;
         up_in      = wrap_edges ? last_ff : '0;
         cmp_idx_in = '0;
      end
      if (cmd.gen_sweep) begin
         // advance the window one row
         up_in      = mid_ff;
         mid_in     = rd_row;
         nxt_in     = gen_row;
         wr_idx_in  = cmp_idx_ff;
         cmp_idx_in = cmp_idx_ff + RIDX_W'(1);
      end
      if (cmd.rsp_load) begin
         alive_in = (op_ff != OP_STEP) && in_range && new_bit;
         range_in = (op_ff == OP_STEP) || in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         wr_pend_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         wr_pend_ff   <= wr_pend_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      wr_idx_ff  <= wr_idx_in;
      up_ff      <= up_in;
      mid_ff     <= mid_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      nxt_ff     <= nxt_in;
      alive_ff   <= alive_in;
      range_ff   <= range_in;
   end

   assign rsp_cell_alive = alive_ff;
   assign rsp_in_range   = range_ff;

endmodule

// ----- bench/tb_life_like_automaton_engine.sv -----
// Self-checking testbench of the life-like automaton engine: grid tracker, drivers, checks.
`timescale 1ns / 1ps

import lla_pkg::*;

typedef struct packed {
   logic alive;
   logic in_range;
} cell_answer_type;

// Tracks the cell grid and the rule registers, and holds the answers still due from the block.
class life_grid_tracker;
   logic [DEFAULT_MAX_COLS-1:0] grid [DEFAULT_MAX_ROWS];
   logic [CFG_SIZE_W-1:0]       rows_cfg;
   logic [CFG_SIZE_W-1:0]       cols_cfg;
   logic [MASK_W-1:0]           born_cfg;
   logic [MASK_W-1:0]           survive_cfg;
   logic                        wrap_cfg;
   cell_answer_type             due_cells [$];
   int unsigned                 mismatches;

   function new();
      foreach (grid[r]) grid[r] = '0;
      rows_cfg    = ROWS_RESET;
      cols_cfg    = COLS_RESET;
      born_cfg    = BORN_RESET;
      survive_cfg = SURVIVE_RESET;
      wrap_cfg    = WRAP_RESET;
      mismatches  = 0;
   endfunction

   // A size of zero acts as one, a size above the grid acts as the grid.
   function int active_rows();
      if (rows_cfg == 0) return 1;
      if (rows_cfg > DEFAULT_MAX_ROWS) return DEFAULT_MAX_ROWS;
      return int'(rows_cfg);
   endfunction

   function int active_cols();
      if (cols_cfg == 0) return 1;
      if (cols_cfg > DEFAULT_MAX_COLS) return DEFAULT_MAX_COLS;
      return int'(cols_cfg);
   endfunction

   function void set_config(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
         REG_ROWS:    rows_cfg    = value[CFG_SIZE_W-1:0];
         REG_COLS:    cols_cfg    = value[CFG_SIZE_W-1:0];
         REG_BORN:    born_cfg    = value[MASK_W-1:0];
         REG_SURVIVE: survive_cfg = value[MASK_W-1:0];
         REG_WRAP:    wrap_cfg    = value[0];
         default: ;
      endcase
   endfunction

   function logic [PDATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_ROWS:    return PDATA_W'(rows_cfg);
         REG_COLS:    return PDATA_W'(cols_cfg);
         REG_BORN:    return PDATA_W'(born_cfg);
         REG_SURVIVE: return PDATA_W'(survive_cfg);
         REG_WRAP:    return PDATA_W'(wrap_cfg);
         default:     return '0;
      endcase
   endfunction

   // With wrap on a grid one or two wide, the same cell may be counted several times.
   function logic next_cell(int r, int c, int nr, int nc);
      int                hits;
      int                rr;
      int                cc;
      logic [MASK_W-1:0] rule;
      hits = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            if (wrap_cfg) begin
               rr = (r + nr + dr) % nr;
               cc = (c + nc + dc) % nc;
            end else begin
               rr = r + dr;
               cc = c + dc;
               if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
            end
            if (grid[rr][cc]) hits++;
         end
      end
      rule = grid[r][c] ? survive_cfg : born_cfg;
      return rule[hits];
   endfunction

   // Update every active cell at once; cells outside the active size keep their value.
   function void advance_generation();
      logic [DEFAULT_MAX_COLS-1:0] fresh [DEFAULT_MAX_ROWS];
      int                          nr;
      int                          nc;
      nr    = active_rows();
      nc    = active_cols();
      fresh = grid;
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            fresh[r][c] = next_cell(r, c, nr, nc);
      grid = fresh;
   endfunction

   function void note_request(lla_op_type op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      cell_answer_type answer;
      if (op == OP_STEP) begin
         advance_generation();
         answer.alive    = 1'b0;
         answer.in_range = 1'b1;
      end else if (row >= active_rows() || col >= active_cols()) begin
         answer.alive    = 1'b0;
         answer.in_range = 1'b0;
      end else begin
         if (op == OP_SET) grid[row][col] = 1'b1;
         else if (op == OP_CLEAR) grid[row][col] = 1'b0;
         answer.alive    = grid[row][col];
         answer.in_range = 1'b1;
      end
      due_cells.push_back(answer);
   endfunction

   function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   function void check_response(logic alive, logic in_range);
      cell_answer_type want;
      if (due_cells.size() == 0) begin
         flag($sformatf("unexpected result: cell_alive=%0b in_range=%0b", alive, in_range));
         return;
      end
      want = due_cells.pop_front();
      if (alive !== want.alive || in_range !== want.in_range)
         flag($sformatf("result mismatch: expected cell_alive=%0b in_range=%0b, got %0b %0b",
                        want.alive, want.in_range, alive, in_range));
   endfunction

   function int outstanding();
      return due_cells.size();
   endfunction
endclass

module tb_life_like_automaton_engine;
   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 4;
   localparam int HOLD_OFF_CYCLES = 400;
   // Every item answers, so the wait after the last answer only lets the block settle.
   localparam int SETTLE_CYCLES   = 8;
   // Leave room after a generation at the full grid for a stray result.
   localparam int TAIL_CYCLES     = 80;
   localparam int CYCLE_LIMIT     = 1_000_000;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_mode_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_operation = '0;
   logic [ROW_W-1:0]   req_row       = '0;
   logic [COL_W-1:0]   req_col       = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic               rsp_cell_alive;
   logic               rsp_in_range;
   logic               psel          = 1'b0;
   logic               penable       = 1'b0;
   logic               pwrite        = 1'b0;
   logic [PADDR_W-1:0] paddr         = '0;
   logic [PDATA_W-1:0] pwdata        = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // Handshake between the sender and the receiver for the one long hold-off.
   bit                 want_hold     = 1'b0;
   bit                 hold_taken    = 1'b0;
   int unsigned        cycle_count   = 0;

   life_grid_tracker   tracker       = new();

   life_like_automaton_engine DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_in_range   (rsp_in_range),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Abort a run that hangs.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Sample both channels at the rising edge. Check the result first: a result can
   // never belong to an item that transfers at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_response(rsp_cell_alive, rsp_in_range);
         if (req_valid && !req_stall)
            tracker.note_request(lla_op_type'(req_operation), req_row, req_col);
      end
   end

   // Receiver: stall on a pattern of its own, switching between no stall, random stall
   // and a periodic stall. Hold off once for a long stretch when the sender asks.
   initial begin : receiver
      stall_mode_type mode;
      int             span;
      int             period;
      forever begin
         mode   = stall_mode_type'($urandom_range(0, 2));
         span   = $urandom_range(20, 200);
         period = $urandom_range(2, 5);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            if (want_hold && !hold_taken) begin
               hold_taken = 1'b1;
               rsp_stall  = 1'b1;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end
            case (mode)
               STALL_NONE:   rsp_stall = 1'b0;
               STALL_RANDOM: rsp_stall = ($urandom_range(0, 99) < 40);
               default:      rsp_stall = ((k % period) == 0);
            endcase
         end
      end
   end

   // Offer one item at the falling edge and hold it until it transfers.
   task automatic send_item(lla_op_type op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      @(negedge clock);
      req_valid     = 1'b1;
      req_operation = op;
      req_row       = row;
      req_col       = col;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Two-phase register write, then read the register back.
   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_config(idx, value);
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== tracker.reg_value(idx))
         tracker.flag($sformatf("register %0d read back %0h, expected %0h",
                                idx, prdata, tracker.reg_value(idx)));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Wait for every outstanding answer, then let the block settle.
   task automatic wait_idle();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Change the rules only with the block idle.
   task automatic configure(int rows, int cols, int born, int survive, int wrap);
      wait_idle();
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
      write_reg(REG_BORN, born);
      write_reg(REG_SURVIVE, survive);
      write_reg(REG_WRAP, wrap);
   endtask

   // Mostly positions inside the active size, sometimes anywhere on the field.
   function automatic logic [ROW_W-1:0] pick_coord(int extent);
      if ($urandom_range(0, 99) < 85) return ROW_W'($urandom_range(0, extent - 1));
      return ROW_W'($urandom_range(0, 63));
   endfunction

   function automatic int pick_size();
      if ($urandom_range(0, 99) < 70) return $urandom_range(1, 12);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 64;
         2:       return 127;
         default: return $urandom_range(13, 126);
      endcase
   endfunction

   task automatic send_random_item(int step_pct);
      lla_op_type op;
      if ($urandom_range(0, 99) < step_pct) begin
         op = OP_STEP;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_SET;
            4, 5:       op = OP_CLEAR;
            default:    op = OP_READ;
         endcase
      end
      send_item(op, pick_coord(tracker.active_rows()), pick_coord(tracker.active_cols()));
   endtask

   // Send items in bursts of random length; an occasional long burst runs without gaps.
   task automatic run_items(int count, int step_pct);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_random_item(step_pct);
            sent++;
         end
         pause_sender($urandom_range(1, 6));
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset rules: full grid, born on three, survive on two or three, dead edges.
      // Touch the corners, set and clear twice, then run a blinker one generation.
      send_item(OP_READ, 6'd0, 6'd0);
      send_item(OP_SET, 6'd0, 6'd0);
      send_item(OP_READ, 6'd0, 6'd0);
      send_item(OP_SET, 6'd63, 6'd63);
      send_item(OP_CLEAR, 6'd63, 6'd63);
      send_item(OP_CLEAR, 6'd63, 6'd63);
      send_item(OP_READ, 6'd63, 6'd63);
      send_item(OP_SET, 6'd0, 6'd63);
      send_item(OP_SET, 6'd63, 6'd0);
      send_item(OP_SET, 6'd10, 6'd10);
      send_item(OP_SET, 6'd10, 6'd11);
      send_item(OP_SET, 6'd10, 6'd12);
      send_item(OP_STEP, 6'd0, 6'd0);
      send_item(OP_READ, 6'd9, 6'd11);
      send_item(OP_READ, 6'd11, 6'd11);
      send_item(OP_READ, 6'd10, 6'd10);
      send_item(OP_READ, 6'd0, 6'd0);
      pause_sender(1);

      // Small wrapped grid: positions past either size are ignored and answer out of range.
      configure(3, 2, BORN_RESET, SURVIVE_RESET, 1);
      send_item(OP_SET, 6'd2, 6'd1);
      send_item(OP_SET, 6'd3, 6'd0);
      send_item(OP_SET, 6'd0, 6'd2);
      send_item(OP_READ, 6'd63, 6'd63);
      send_item(OP_CLEAR, 6'd2, 6'd1);
      send_item(OP_READ, 6'd2, 6'd1);
      send_item(OP_STEP, 6'd63, 6'd63);
      pause_sender(1);

      // Hold off the receiver while a dense run of reads fills the block, then pause
      // the sender until every answer is back.
      configure(64, 64, BORN_RESET, SURVIVE_RESET, 0);
      run_items(60, 5);
      want_hold = 1'b1;
      for (int k = 0; k < 60; k++)
         send_item(OP_READ, ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 63)));
      pause_sender(1);
      want_hold = 1'b0;
      wait_idle();

      // Rule and size settings. Populate the full grid, then shrink
      // and grow again so cells outside the active size come back into view.
      configure(8, 8, BORN_RESET, SURVIVE_RESET, 0);
      run_items(70, 12);
      configure(8, 8, BORN_RESET, SURVIVE_RESET, 1);
      run_items(70, 12);
      configure(0, 0, 511, 511, 1);
      run_items(40, 20);
      configure(1, 2, $urandom_range(0, 511), $urandom_range(0, 511), 1);
      run_items(60, 15);
      configure(2, 1, $urandom_range(0, 511), $urandom_range(0, 511), 1);
      run_items(60, 15);
      configure(2, 2, $urandom_range(0, 511), $urandom_range(0, 511), 1);
      run_items(60, 15);
      configure(3, 3, BORN_RESET, SURVIVE_RESET, 1);
      run_items(60, 15);
      configure(127, 127, BORN_RESET, SURVIVE_RESET, 0);
      run_items(80, 5);
      configure(5, 9, 511, 0, 0);
      run_items(60, 12);
      configure(16, 16, BORN_RESET, SURVIVE_RESET, 1);
      run_items(70, 10);
      configure(12, 10, $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1));
      run_items(70, 12);
      configure(100, 3, $urandom_range(0, 511), $urandom_range(0, 511), 1);
      run_items(60, 8);
      configure(4, 64, $urandom_range(0, 511), $urandom_range(0, 511), 0);
      run_items(60, 12);
      configure(64, 64, 0, 0, 1);
      run_items(50, 8);

      // Random settings, mostly small grids.
      for (int p = 0; p < 5; p++) begin
         configure(pick_size(), pick_size(), $urandom_range(0, 511), $urandom_range(0, 511),
                   $urandom_range(0, 1));
         run_items(70, 12);
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
